FILE: rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Types and constants for the bit-packed entry store.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int STORE_BYTES_DEF = 4096;
  localparam int MAX_WIDTH       = 32;
  localparam int WIDTH_RESET     = 8;
  localparam int MAX_ENTRIES     = 32768;
  localparam int WIN_BYTES       = 5;
  localparam int WIN_W           = WIN_BYTES * 8;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_APPEND = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_XFER,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [14:0] index;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [15:0] entry_count;
  } out_item_t;

endpackage

FILE: rtl/bit_packed_array_store.sv
// ----------------------------------------------------------------------------
// bit_packed_array_store
// Byte store holding entries of 1 to 32 bits packed back to back.
//
// Input channel (in_valid/in_stall/in_data) carries write, read and append
// commands; the result channel (out_valid/out_stall/out_data) returns one
// result per command with the read data, a status and the entry count.
// cfg_we/cfg_wdata set the entry width; write it only while the block is idle.
//
// An entry spanning N store bytes (1 to 5) is moved one byte per cycle
// through the byte memory, reading byte k+1 while byte k is merged and
// written back (or, for a read, collected). A new command is taken only in
// S_IDLE, once the previous result has been loaded. A command that fails
// its range or full check, or the unused command code, touches no byte.
//
// Reset clears the entry count, sets the width to 8 and empties the output
// register; the store contents are left as they are. A finished result waits
// in the output register while out_stall is high, and the next command can
// be taken meanwhile; it completes once that result has been transferred.
// ----------------------------------------------------------------------------
module bit_packed_array_store #(
  parameter int STORE_BYTES = bpa_pkg::STORE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bpa_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bpa_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata
);
  import bpa_pkg::*;

  localparam int AW         = $clog2(STORE_BYTES);
  localparam int STORE_BITS = STORE_BYTES * 8;

  logic [7:0] mem [STORE_BYTES];

  state_t      state_r, state_nxt;
  logic [15:0] entries_r, entries_nxt;
  logic [5:0]  width_r, width_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        rd_vld_r, rd_vld_nxt;
  logic [2:0]  rk_r, rk_nxt;
  logic [2:0]  wk_r, wk_nxt;

  logic [1:0]        cmd_r, cmd_nxt;
  logic [14:0]       idx_r, idx_nxt;
  logic [31:0]       val_r, val_nxt;
  logic [5:0]        w_r, w_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [2:0]        shift_r, shift_nxt;
  logic [2:0]        nbytes_r, nbytes_nxt;
  status_t           st_r, st_nxt;
  logic [WIN_W-1:0]  d_r, d_nxt;
  logic [WIN_W-1:0]  m_r, m_nxt;
  logic [WIN_W-1:0]  acc_r, acc_nxt;
  out_item_t         out_r, out_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wbyte;
  logic [7:0]    rdata_r;

  logic [15:0]      n_pos;
  logic [21:0]      bit_pos;
  logic [22:0]      end_pos;
  logic             fits;
  logic [AW+18:0]   base_ext;
  logic [5:0]       span;
  logic [31:0]      mask32;
  logic             load_out;

  always_comb begin
    state_nxt     = state_r;
    entries_nxt   = entries_r;
    width_nxt     = cfg_we ? cfg_wdata : width_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_vld_nxt    = 1'b0;
    rk_nxt        = rk_r;
    wk_nxt        = wk_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    w_nxt         = w_r;
    base_nxt      = base_r;
    shift_nxt     = shift_r;
    nbytes_nxt    = nbytes_r;
    st_nxt        = st_r;
    d_nxt         = d_r;
    m_nxt         = m_r;
    acc_nxt       = acc_r;
    out_nxt       = out_r;
    in_stall      = 1'b1;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    waddr         = base_r + AW'(wk_r);
    raddr         = base_r + AW'(rk_r);
    wbyte         = (rdata_r & ~m_r[7:0]) | d_r[7:0];
    load_out      = 1'b0;

    n_pos    = (cmd_r == CMD_APPEND) ? entries_r : {1'b0, idx_r};
    bit_pos  = 22'(n_pos) * 22'(w_r);
    end_pos  = 23'(bit_pos) + 23'(w_r);
    fits     = 32'(end_pos) <= 32'(STORE_BITS);
    base_ext = {{AW{1'b0}}, bit_pos[21:3]};
    span     = 6'(bit_pos[2:0]) + w_r + 6'd7;
    mask32   = (w_r == 6'(MAX_WIDTH)) ? '1 : ((32'd1 << w_r) - 32'd1);

    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_nxt = in_data.command;
          idx_nxt = in_data.index;
          val_nxt = in_data.value;
          if (width_r == 6'd0) begin
            w_nxt = 6'd1;
          end else if (width_r > 6'(MAX_WIDTH)) begin
            w_nxt = 6'(MAX_WIDTH);
          end else begin
            w_nxt = width_r;
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        base_nxt   = base_ext[AW-1:0];
        shift_nxt  = bit_pos[2:0];
        nbytes_nxt = span[5:3];
        d_nxt      = WIN_W'(val_r & mask32) << bit_pos[2:0];
        m_nxt      = WIN_W'(mask32) << bit_pos[2:0];
        acc_nxt    = '0;
        rk_nxt     = '0;
        wk_nxt     = '0;
        st_nxt     = ST_OK;
        state_nxt  = S_FINISH;
        case (cmd_r)
          CMD_WRITE, CMD_READ: begin
            if (16'(idx_r) >= entries_r || !fits) begin
              st_nxt = ST_RANGE;
            end else begin
              state_nxt = S_XFER;
            end
          end
          CMD_APPEND: begin
            if (entries_r >= 16'(MAX_ENTRIES) || !fits) begin
              st_nxt = ST_FULL;
            end else begin
              entries_nxt = entries_r + 16'd1;
              state_nxt   = S_XFER;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_XFER: begin
        if (rk_r < nbytes_r) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          rk_nxt     = rk_r + 3'd1;
        end
        if (rd_vld_r) begin
          if (cmd_r == CMD_READ) begin
            acc_nxt[{wk_r, 3'b000} +: 8] = rdata_r;
          end else begin
            wr_en = 1'b1;
            d_nxt = d_r >> 8;
            m_nxt = m_r >> 8;
          end
          wk_nxt = wk_r + 3'd1;
          if (wk_r + 3'd1 == nbytes_r) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        load_out = !out_valid_r || !out_stall;
        if (load_out) begin
          out_nxt.read_value  = ((cmd_r == CMD_READ) && (st_r == ST_OK)) ?
                                32'((acc_r & m_r) >> shift_r) : 32'd0;
          out_nxt.status      = st_r;
          out_nxt.entry_count = entries_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      entries_r   <= '0;
      width_r     <= 6'(WIDTH_RESET);
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      rk_r        <= '0;
      wk_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      entries_r   <= entries_nxt;
      width_r     <= width_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rk_r        <= rk_nxt;
      wk_r        <= wk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    w_r      <= w_nxt;
    base_r   <= base_nxt;
    shift_r  <= shift_nxt;
    nbytes_r <= nbytes_nxt;
    st_r     <= st_nxt;
    d_r      <= d_nxt;
    m_r      <= m_nxt;
    acc_r    <= acc_nxt;
    out_r    <= out_nxt;
  end

  // byte store: one write and one read port, registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wbyte;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    entries_r <= 16'(MAX_ENTRIES))
    else $error("entry count beyond limit");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (entries_r != $past(entries_r)) |->
      (entries_r == $past(entries_r) + 16'd1) && ($past(state_r) == S_CHECK))
    else $error("entry count changed outside an append");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_XFER) && (cmd_r != CMD_READ))
    else $error("store written by a read");

  a_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_XFER) |->
      (nbytes_r != 3'd0) && (nbytes_r <= 3'(WIN_BYTES)) && (wk_r < nbytes_r))
    else $error("byte window out of bounds");

  a_full_is_append: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && (st_r == ST_FULL) |-> (cmd_r == CMD_APPEND))
    else $error("full status on a non-append");

endmodule
